[hw/rtl/r2nv_pkg.sv]
// Shared types, register codes and constants for the RGB to NV12 converter.
`timescale 1ns / 1ps

package r2nv_pkg;

    localparam int CFG_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int LUMA_IDX_W     = 24;
    localparam int CHROMA_IDX_W   = 23;
    localparam int MAX_DIM_DEFAULT = 4096;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_PIXELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LINES = 2'd1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0]                  luma;
        logic [7:0]                  cb;
        logic [7:0]                  cr;
        logic                        chroma_valid;
        logic [LUMA_IDX_W-1:0]       luma_index;
        logic [CHROMA_IDX_W-1:0]     chroma_index;
        logic                        end_of_frame;
    } result_t;

    // Raster position info of one pixel, produced by the position unit
    typedef struct packed {
        logic                        chroma_valid;
        logic [LUMA_IDX_W-1:0]       luma_index;
        logic [CHROMA_IDX_W-1:0]     chroma_index;
        logic                        end_of_frame;
    } pos_t;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
    } color_t;

endpackage

[hw/rtl/r2nv_csc.sv]
// BT.601 video-range color space conversion of one pixel.
`timescale 1ns / 1ps

module r2nv_csc
    import r2nv_pkg::*;
(
    input  pixel_t pix,
    output color_t color
);

    logic        [16:0] luma_sum;
    logic        [16:0] luma_val;
    logic signed [17:0] rs;
    logic signed [17:0] gs;
    logic signed [17:0] bs;
    logic signed [17:0] cb_sum;
    logic signed [17:0] cr_sum;
    logic signed [17:0] cb_val;
    logic signed [17:0] cr_val;

    assign rs = signed'({10'd0, pix.red});
    assign gs = signed'({10'd0, pix.green});
    assign bs = signed'({10'd0, pix.blue});

    assign luma_sum = 17'd66 * {9'd0, pix.red} + 17'd129 * {9'd0, pix.green}
                    + 17'd25 * {9'd0, pix.blue} + 17'd128;
    assign luma_val = (luma_sum >> 8) + 17'd16;

    // Arithmetic shift floors negative sums
    assign cb_sum = -18'sd38 * rs - 18'sd74 * gs + 18'sd112 * bs + 18'sd128;
    assign cr_sum = 18'sd112 * rs - 18'sd94 * gs - 18'sd18 * bs + 18'sd128;
    assign cb_val = (cb_sum >>> 8) + 18'sd128;
    assign cr_val = (cr_sum >>> 8) + 18'sd128;

    always_comb
    begin
        if (luma_val > 17'd235)
        begin
            color.luma = 8'd235;
        end
        else
        begin
            color.luma = luma_val[7:0];
        end

        if (cb_val < 18'sd16)
        begin
            color.cb = 8'd16;
        end
        else if (cb_val > 18'sd240)
        begin
            color.cb = 8'd240;
        end
        else
        begin
            color.cb = cb_val[7:0];
        end

        if (cr_val < 18'sd16)
        begin
            color.cr = 8'd16;
        end
        else if (cr_val > 18'sd240)
        begin
            color.cr = 8'd240;
        end
        else
        begin
            color.cr = cr_val[7:0];
        end
    end

endmodule

[hw/rtl/r2nv_pos.sv]
// Column and row counters with Y and UV plane offsets.
`timescale 1ns / 1ps

module r2nv_pos
    import r2nv_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIM_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [CFG_W-1:0] line_pixels,
    input  logic [CFG_W-1:0] frame_lines,
    output pos_t             pos
);

    localparam int CNT_W = $clog2(MAX_DIMENSION);
    localparam int DIM_W = CNT_W + 1;
    localparam int CMP_W = CFG_W + 1;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_DIMENSION);

    logic [CNT_W-1:0]      col_reg;
    logic [CNT_W-1:0]      col_next;
    logic [CNT_W-1:0]      row_reg;
    logic [CNT_W-1:0]      row_next;
    logic [LUMA_IDX_W-1:0] base_reg;
    logic [LUMA_IDX_W-1:0] base_next;

    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] height_ext;
    logic [CMP_W-1:0] width_eff;
    logic [CMP_W-1:0] height_eff;
    logic [DIM_W-1:0] width_dim;
    logic [DIM_W-1:0] height_dim;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic             last_col;
    logic             last_row;

    assign width_ext  = {1'b0, line_pixels};
    assign height_ext = {1'b0, frame_lines};

    // Zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (width_ext == '0)
        begin
            width_eff = CMP_W'(1);
        end
        else if (width_ext > MAX_CMP)
        begin
            width_eff = MAX_CMP;
        end
        else
        begin
            width_eff = width_ext;
        end

        if (height_ext == '0)
        begin
            height_eff = CMP_W'(1);
        end
        else if (height_ext > MAX_CMP)
        begin
            height_eff = MAX_CMP;
        end
        else
        begin
            height_eff = height_ext;
        end
    end

    assign width_dim  = width_eff[DIM_W-1:0];
    assign height_dim = height_eff[DIM_W-1:0];
    assign col_inc    = {1'b0, col_reg} + DIM_W'(1);
    assign row_inc    = {1'b0, row_reg} + DIM_W'(1);
    assign last_col   = col_inc >= width_dim;
    assign last_row   = row_inc >= height_dim;

    assign pos.chroma_valid = ~col_reg[0] & ~row_reg[0];
    assign pos.luma_index   = base_reg + LUMA_IDX_W'(col_reg);
    assign pos.chroma_index = base_reg[LUMA_IDX_W-1:1] + CHROMA_IDX_W'(col_reg);
    assign pos.end_of_frame = last_col & last_row;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (advance)
        begin
            if (!last_col)
            begin
                col_next = col_inc[CNT_W-1:0];
            end
            else
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next  = '0;
                    base_next = '0;
                end
                else
                begin
                    row_next  = row_inc[CNT_W-1:0];
                    base_next = base_reg + LUMA_IDX_W'(width_dim);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

endmodule

[hw/rtl/rgb_to_nv12_converter.sv]
// Top level of the RGB888 to NV12 (BT.601 video range) pixel converter.
//
// Pixels enter on the pixel channel (pixel, pixel_valid, pixel_stall) in raster
// order; one result per pixel leaves on the result channel (result,
// result_valid, result_stall). A transfer happens on a clock edge with valid
// high and stall low.
// A pixel and its position wait in the input register, then its result in the
// result register; result_valid rises when the result register takes the result.
// Throughput: one pixel per clock while the receiver does not stall, set by the
// two-stage register pipeline. When the receiver stalls, the result register
// holds and the input register fills; pixel_stall rises only when both stages
// hold data. The line length and line count registers are written through
// cfg_write_en, cfg_index and cfg_data; the user must write them only while
// the block is idle; the block does not enforce it. Reset empties the pipeline,
// sets the frame to 640 x 480 and puts the position at column 0, row 0.
// chroma_valid marks pixels at even column and even row; cb, cr and
// chroma_index are zero on the other pixels. end_of_frame marks the last pixel.
`timescale 1ns / 1ps

module rgb_to_nv12_converter
    import r2nv_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIM_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pixel_t               pixel,
    input  logic                 pixel_valid,
    output logic                 pixel_stall,
    output result_t              result,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    logic    s1_valid_reg;
    pixel_t  s1_pix_reg;
    pos_t    s1_pos_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic    out_load;
    logic    s1_load;
    logic    accept;
    pos_t    pos;
    color_t  color;
    result_t out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_LINE_PIXELS: width_reg  <= cfg_data;
                REG_FRAME_LINES: height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Advance each stage when the one after it is free or draining
    assign out_load    = !out_valid_reg || !result_stall;
    assign s1_load     = !s1_valid_reg || out_load;
    assign pixel_stall = !s1_load;
    assign accept      = pixel_valid && s1_load;

    r2nv_pos #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .line_pixels (width_reg),
        .frame_lines (height_reg),
        .pos         (pos)
    );

    r2nv_csc u_csc (
        .pix   (s1_pix_reg),
        .color (color)
    );

    always_comb
    begin
        out_next.luma         = color.luma;
        out_next.chroma_valid = s1_pos_reg.chroma_valid;
        out_next.luma_index   = s1_pos_reg.luma_index;
        out_next.end_of_frame = s1_pos_reg.end_of_frame;
        if (s1_pos_reg.chroma_valid)
        begin
            out_next.cb           = color.cb;
            out_next.cr           = color.cr;
            out_next.chroma_index = s1_pos_reg.chroma_index;
        end
        else
        begin
            out_next.cb           = '0;
            out_next.cr           = '0;
            out_next.chroma_index = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= pixel_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= pixel;
            s1_pos_reg <= pos;
        end
        if (out_load && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule
